// ----- src/gws_pkg.sv -----
// Shared types and constants for the occupancy grid window sum block.
package gws_pkg;

  localparam int MAX_MAP_DIM = 256;
  localparam int MAX_WINDOW_DIM = 512;
  localparam int MAP_DEPTH = MAX_MAP_DIM * MAX_MAP_DIM;
  localparam int MAP_AW = $clog2(MAP_DEPTH);
  localparam int DIM_W = 9;
  localparam int CELL_W = 8;
  localparam int SUM_W = 32;
  localparam logic signed [SUM_W-1:0] OOB_PENALTY = 32'sd1000;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic REG_MAP_WIDTH = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_COL,
    ST_FLUSH,
    ST_DONE
  } gws_state_t;

  typedef enum logic [1:0] {
    ADD_NONE,
    ADD_PEN,
    ADD_CELL
  } add_sel_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > MAX_MAP_DIM) begin
      r = DIM_W'(MAX_MAP_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- src/grid_window_sum_with_bounds_penalty.sv -----
// Occupancy grid window sum: top level with cell store and query sequencer.
//
// Usage: the input channel (in_valid/in_stall) carries one request per
// accepted cycle. A request with cmd at zero writes cell_value into the map
// at cell_index and gives no result. A request with cmd at one sums the
// rectangle given by offset_x, offset_y, size_x and size_y and gives one
// area_sum on the output channel (out_valid/out_stall).
// The configuration port sets map_width (index 0) and map_height (index 1).
// The user writes it only while no query is in flight; the block does not check.
// A query walks the window row by row. A row above the map adds a penalty;
// a row inside it is entered, then its columns are visited one at a time,
// each adding a cell or, left of the map, a penalty. A column past the right
// edge or a row below the map adds one penalty and ends the row or the walk.
// ST_FLUSH and ST_DONE drain the single adder; a write never raises in_stall.
// While a query runs in_stall is high. A finished sum waits in the output
// register while the receiver stalls; writes and the next query are taken
// meanwhile, and that query holds its sum until the register frees up.
// Reset sets both map dimensions to 256 and empties the output register;
// the map contents are undefined until written.
module grid_window_sum_with_bounds_penalty
  import gws_pkg::*;
#(
  parameter int MaxWindowDim = MAX_WINDOW_DIM
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [DIM_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    cmd,
  input  logic [MAP_AW-1:0]       cell_index,
  input  logic signed [CELL_W-1:0] cell_value,
  input  logic signed [9:0]       offset_x,
  input  logic signed [9:0]       offset_y,
  input  logic [9:0]              size_x,
  input  logic [9:0]              size_y,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [SUM_W-1:0] area_sum
);

  localparam int WW = $clog2(MaxWindowDim + 1);
  localparam int PW = ((WW > 10) ? WW : 10) + 2;
  localparam int AW = PW + DIM_W + 1;
  localparam logic [WW-1:0] WIN_MAX = WW'(MaxWindowDim);

  gws_state_t state;
  gws_state_t state_next;

  logic [DIM_W-1:0] map_width;
  logic [DIM_W-1:0] map_height;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic signed [PW-1:0] w_pos;
  logic signed [PW-1:0] h_pos;
  logic signed [DIM_W:0] w_s;

  logic signed [PW-1:0] pos_x;
  logic signed [PW-1:0] pos_y;
  logic signed [PW-1:0] start_x;
  logic [WW-1:0] rem_x;
  logic [WW-1:0] rem_y;
  logic [WW-1:0] span_x;
  logic signed [AW-1:0] row_base;
  logic signed [SUM_W-1:0] acc;
  add_sel_t add_sel;

  logic accept;
  logic start_query;
  logic do_pen;
  logic do_cell;
  logic row_step;
  logic col_step;
  logic row_enter;
  logic [WW-1:0] sat_x;
  logic [WW-1:0] sat_y;

  logic mem_we;
  logic [MAP_AW-1:0] rd_addr;
  logic [CELL_W-1:0] rd_data;
  logic signed [AW-1:0] addr_full;

  assign w_eff = clamp_dim(map_width);
  assign h_eff = clamp_dim(map_height);
  assign w_pos = PW'(w_eff);
  assign h_pos = PW'(h_eff);
  assign w_s = {1'b0, w_eff};

  assign sat_x = (int'(size_x) > MaxWindowDim) ? WIN_MAX : WW'(size_x);
  assign sat_y = (int'(size_y) > MaxWindowDim) ? WIN_MAX : WW'(size_y);

  assign in_stall = (state != ST_IDLE);
  assign accept = in_valid && !in_stall;
  assign start_query = accept && (cmd == CMD_QUERY);
  assign mem_we = accept && (cmd == CMD_WRITE);

  assign addr_full = row_base + AW'(pos_x);
  assign rd_addr = addr_full[MAP_AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width <= DIM_W'(MAX_MAP_DIM);
      map_height <= DIM_W'(MAX_MAP_DIM);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAP_WIDTH:  map_width <= cfg_data;
        REG_MAP_HEIGHT: map_height <= cfg_data;
        default:        map_width <= map_width;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start_query) begin
          state_next = ST_ROW;
        end
      end
      ST_ROW: begin
        if (rem_y == '0 || pos_y >= h_pos) begin
          state_next = ST_FLUSH;
        end else if (pos_y >= 0) begin
          state_next = ST_COL;
        end
      end
      ST_COL: begin
        if (rem_x == '0 || pos_x >= w_pos) begin
          state_next = ST_ROW;
        end
      end
      ST_FLUSH: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    do_pen = 1'b0;
    do_cell = 1'b0;
    row_step = 1'b0;
    col_step = 1'b0;
    row_enter = 1'b0;
    unique case (state)
      ST_ROW: begin
        if (rem_y != '0) begin
          if (pos_y < 0) begin
            do_pen = 1'b1;
            row_step = 1'b1;
          end else if (pos_y >= h_pos) begin
            do_pen = 1'b1;
          end else begin
            row_enter = 1'b1;
          end
        end
      end
      ST_COL: begin
        if (rem_x == '0) begin
          row_step = 1'b1;
        end else if (pos_x < 0) begin
          do_pen = 1'b1;
          col_step = 1'b1;
        end else if (pos_x >= w_pos) begin
          do_pen = 1'b1;
          row_step = 1'b1;
        end else begin
          do_cell = 1'b1;
          col_step = 1'b1;
        end
      end
      default: begin
        do_pen = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      add_sel <= ADD_NONE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (do_cell) begin
        add_sel <= ADD_CELL;
      end else if (do_pen) begin
        add_sel <= ADD_PEN;
      end else begin
        add_sel <= ADD_NONE;
      end
      if (state == ST_DONE && state_next == ST_IDLE) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_query) begin
      acc <= '0;
      start_x <= PW'(offset_x);
      pos_y <= PW'(offset_y);
      rem_y <= sat_y;
      span_x <= sat_x;
      row_base <= AW'(offset_y) * AW'(w_s);
    end else begin
      unique case (add_sel)
        ADD_CELL: acc <= acc + SUM_W'(signed'(rd_data));
        ADD_PEN:  acc <= acc + OOB_PENALTY;
        default:  acc <= acc;
      endcase
      if (row_step) begin
        pos_y <= pos_y + PW'(1);
        rem_y <= rem_y - WW'(1);
        row_base <= row_base + AW'(w_s);
      end
    end
    if (row_enter) begin
      pos_x <= start_x;
      rem_x <= span_x;
    end else if (col_step) begin
      pos_x <= pos_x + PW'(1);
      rem_x <= rem_x - WW'(1);
    end
    if (state == ST_DONE && state_next == ST_IDLE) begin
      area_sum <= acc;
    end
  end

  gws_map_mem u_map_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (cell_index),
    .wr_data (cell_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// ----- src/gws_map_mem.sv -----
// Map cell store: one write port and one registered read port.
module gws_map_mem
  import gws_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [MAP_AW-1:0] wr_addr,
  input  logic [CELL_W-1:0] wr_data,
  input  logic [MAP_AW-1:0] rd_addr,
  output logic [CELL_W-1:0] rd_data
);

  logic [CELL_W-1:0] cells [MAP_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cells[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= cells[rd_addr];
  end

endmodule

// ----- src/gws_checker.sv -----
// Port-level checker for the grid window sum block, bound to the top level.
module gws_checker
  import gws_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    cmd,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [SUM_W-1:0] area_sum
);

  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("Result request dropped while stalled.");

  a_out_stable : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(area_sum))
    else $error("Result changed while stalled.");

  a_query_busy : assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (cmd == CMD_QUERY) |=> in_stall)
    else $error("Block took a request right after a query.");

  a_result_after_busy : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("Result appeared without a query in flight.");

  a_write_no_result : assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (cmd == CMD_WRITE) && !out_valid |=> !out_valid)
    else $error("Cell write produced a result.");

endmodule

bind grid_window_sum_with_bounds_penalty gws_checker u_gws_checker (.*);

// ----- bench/tb.sv -----
// Self-checking testbench for the occupancy grid window sum block.
module tb;
  import gws_pkg::*;

  localparam int IDLE_LIMIT = 50000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    logic                     op;
    logic [MAP_AW-1:0]        index;
    logic signed [CELL_W-1:0] value;
    logic signed [9:0]        ox;
    logic signed [9:0]        oy;
    logic [9:0]               sx;
    logic [9:0]               sy;
  } grid_req_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic                     cfg_index = REG_MAP_WIDTH;
  logic [DIM_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     cmd = CMD_WRITE;
  logic [MAP_AW-1:0]        cell_index = '0;
  logic signed [CELL_W-1:0] cell_value = '0;
  logic signed [9:0]        offset_x = '0;
  logic signed [9:0]        offset_y = '0;
  logic [9:0]               size_x = '0;
  logic [9:0]               size_y = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [SUM_W-1:0]  area_sum;

  logic signed [CELL_W-1:0] grid_cells [MAP_DEPTH];
  bit                       grid_written [MAP_DEPTH];
  logic [DIM_W-1:0]         width_reg = DIM_W'(256);
  logic [DIM_W-1:0]         height_reg = DIM_W'(256);
  logic signed [SUM_W-1:0]  sums_pending [$];
  int unsigned              fill_q [$];
  int                       send_idle_pct = 17;
  int                       recv_idle_pct = 72;
  int                       items_sent = 0;
  int                       failures = 0;
  int                       idle_cycles = 0;

  grid_window_sum_with_bounds_penalty dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .cell_index(cell_index),
    .cell_value(cell_value),
    .offset_x(offset_x),
    .offset_y(offset_y),
    .size_x(size_x),
    .size_y(size_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .area_sum(area_sum)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int usable_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    return (int'(v) > MAX_MAP_DIM) ? MAX_MAP_DIM : int'(v);
  endfunction

  function automatic grid_req_t make_request(input logic op, input int idx, input int val,
                                             input int ox, input int oy,
                                             input int sx, input int sy);
    grid_req_t r;
    r.op = op;
    r.index = idx[MAP_AW-1:0];
    r.value = val[CELL_W-1:0];
    r.ox = ox[9:0];
    r.oy = oy[9:0];
    r.sx = sx[9:0];
    r.sy = sy[9:0];
    return r;
  endfunction

  // Walks the window exactly as the block does. With collect set, every
  // cell that would be read without having been written is also queued.
  function automatic longint walk_window(input grid_req_t r, input bit collect);
    int w, h, ox, oy, sx, sy, x, y;
    int unsigned idx;
    longint acc;
    w = usable_dim(width_reg);
    h = usable_dim(height_reg);
    ox = int'(r.ox);
    oy = int'(r.oy);
    sx = (int'(r.sx) > MAX_WINDOW_DIM) ? MAX_WINDOW_DIM : int'(r.sx);
    sy = (int'(r.sy) > MAX_WINDOW_DIM) ? MAX_WINDOW_DIM : int'(r.sy);
    acc = 0;
    for (y = oy; y < oy + sy; y++) begin
      if (y >= 0 && y < h) begin
        for (x = ox; x < ox + sx; x++) begin
          if (x >= 0 && x < w) begin
            idx = (y * w + x) % MAP_DEPTH;
            if (collect && !grid_written[idx]) fill_q.push_back(idx);
            acc = acc + grid_cells[idx];
          end else begin
            acc = acc + OOB_PENALTY;
            if (x >= w) break;
          end
        end
      end else begin
        acc = acc + OOB_PENALTY;
        if (y >= h) break;
      end
    end
    return acc;
  endfunction

  task automatic send_request(input grid_req_t r);
    longint full_sum;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= r.op;
    cell_index <= r.index;
    cell_value <= r.value;
    offset_x <= r.ox;
    offset_y <= r.oy;
    size_x <= r.sx;
    size_y <= r.sy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (r.op == CMD_WRITE) begin
      grid_cells[r.index] = r.value;
      grid_written[r.index] = 1'b1;
    end else begin
      full_sum = walk_window(r, 1'b0);
      sums_pending.push_back(full_sum[SUM_W-1:0]);
    end
    items_sent++;
  endtask

  // Fills every cell the query would read that holds no value yet.
  task automatic send_query(input grid_req_t r);
    longint unused_sum;
    fill_q.delete();
    unused_sum = walk_window(r, 1'b1);
    while (fill_q.size() != 0) begin
      send_request(make_request(CMD_WRITE, fill_q.pop_front(), $urandom_range(255),
                                0, 0, 0, 0));
    end
    send_request(r);
  endtask

  task automatic wait_for_sums();
    in_valid <= 1'b0;
    while (sums_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_map_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    cfg_we <= 1'b1;
    cfg_index <= REG_MAP_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= REG_MAP_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    width_reg = w;
    height_reg = h;
  endtask

  task automatic test_directed();
    wait_for_sums();
    set_map_size(DIM_W'(4), DIM_W'(3));
    send_request(make_request(CMD_WRITE, 65535, -128, 0, 0, 0, 0));
    send_request(make_request(CMD_WRITE, 0, 127, 0, 0, 0, 0));
    send_query(make_request(CMD_QUERY, 0, 0, 0, 0, 2, 2));
    send_query(make_request(CMD_QUERY, 0, 0, 0, 0, 0, 5));
    send_query(make_request(CMD_QUERY, 0, 0, 1, 1, 3, 0));
    send_query(make_request(CMD_QUERY, 0, 0, 0, -512, 1, 1023));
    send_query(make_request(CMD_QUERY, 0, 0, -512, 0, 1023, 1));
    send_query(make_request(CMD_QUERY, 0, 0, 2, 1, 10, 10));
    send_query(make_request(CMD_QUERY, 0, 0, 511, 511, 512, 1));
    send_query(make_request(CMD_QUERY, 0, 0, -1, -1, 3, 3));
    wait_for_sums();
    set_map_size(DIM_W'(0), DIM_W'(511));
    send_query(make_request(CMD_QUERY, 0, 0, 0, 250, 3, 10));
    wait_for_sums();
    set_map_size(DIM_W'(256), DIM_W'(256));
    send_query(make_request(CMD_QUERY, 0, 0, 254, 254, 4, 4));
  endtask

  task automatic test_random(input int goal, input int send_pct, input int recv_pct);
    int seg, start, pick, w, h, span_x, span_y, base_x, base_y;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (seg = 0; seg < 5; seg++) begin
      wait_for_sums();
      case (seg)
        0: set_map_size(DIM_W'($urandom_range(1)), DIM_W'($urandom_range(1)));
        1: set_map_size($urandom_range(1) ? DIM_W'(511) : DIM_W'(256),
                        DIM_W'($urandom_range(1, 8)));
        2: set_map_size(DIM_W'($urandom_range(1, 8)),
                        $urandom_range(1) ? DIM_W'(511) : DIM_W'(256));
        3: set_map_size(DIM_W'($urandom_range(1, 24)), DIM_W'($urandom_range(1, 24)));
        default: set_map_size(DIM_W'($urandom_range(200, 511)),
                              DIM_W'($urandom_range(200, 511)));
      endcase
      w = usable_dim(width_reg);
      h = usable_dim(height_reg);
      span_x = (w < 12) ? w : 12;
      span_y = (h < 12) ? h : 12;
      start = items_sent;
      while (items_sent - start < goal) begin
        pick = $urandom_range(99);
        if (pick < 25) begin
          send_request(make_request(CMD_WRITE, $urandom_range(65535), $urandom_range(255),
                                    0, 0, 0, 0));
        end else if (pick < 40 && h <= 8 && w * h <= 64) begin
          send_query(make_request(CMD_QUERY, 0, 0,
                                  int'($urandom_range(1023)) - 512,
                                  int'($urandom_range(1023)) - 512,
                                  $urandom_range(1023), $urandom_range(1023)));
        end else begin
          base_x = ($urandom_range(3) == 0) ? w - span_x : 0;
          base_y = ($urandom_range(3) == 0) ? h - span_y : 0;
          send_query(make_request(CMD_QUERY, 0, 0,
                                  base_x + int'($urandom_range(span_x + 7)) - 4,
                                  base_y + int'($urandom_range(span_y + 7)) - 4,
                                  $urandom_range(span_x + 4), $urandom_range(span_y + 4)));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin : check_sums
    logic signed [SUM_W-1:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (sums_pending.size() == 0) begin
        $display("%0t: area_sum expected none actual %0d", $time, area_sum);
        failures++;
      end else begin
        want = sums_pending.pop_front();
        if (area_sum !== want) begin
          $display("%0t: area_sum expected %0d actual %0d", $time, want, area_sum);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("grid_window_sum_with_bounds_penalty verification failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(117, 17, 72);
    test_random(117, 72, 17);
    test_random(117, 0, 0);
    wait_for_sums();
    if (failures == 0) begin
      $display("grid_window_sum_with_bounds_penalty verification clean");
    end else begin
      $display("grid_window_sum_with_bounds_penalty verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/gws_pkg.sv
src/gws_map_mem.sv
src/grid_window_sum_with_bounds_penalty.sv
src/gws_checker.sv
bench/tb.sv
